>>> src/pmlt_pkg.sv
package pmlt_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned PinW    = 4;
  localparam int unsigned HoldW   = 27;
  localparam int unsigned ShortW  = 16;
  localparam int unsigned NumChan = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 27;

  // Item modes.
  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_PIN     = 2'd1;
  localparam logic [1:0] MODE_CANCEL  = 2'd2;
  localparam logic [1:0] MODE_RESTART = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_PIN_OUTSIDE    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PIN_ENTRANCE   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_OUTSIDE   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_ENTRANCE  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_GLITCH_TIME    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_VALID_LOW_TIME = 3'd5;

  // Register reset values.
  localparam logic [PinW-1:0]   RST_PIN_OUTSIDE    = 4'd0;
  localparam logic [PinW-1:0]   RST_PIN_ENTRANCE   = 4'd1;
  localparam logic [HoldW-1:0]  RST_HOLD_TIME      = 27'd60000;
  localparam logic [ShortW-1:0] RST_GLITCH_TIME    = 16'd30;
  localparam logic [ShortW-1:0] RST_VALID_LOW_TIME = 16'd200;

  typedef struct packed {
    logic [1:0]       mode;
    logic [PinW-1:0]  pin_number;
    logic             pin_level;
    logic             channel;
    logic [TimeW-1:0] now_ms;
    logic             manual_outside;
    logic             manual_entrance;
    logic             suppress_events;
  } in_item_t;

  typedef struct packed {
    logic [NumChan-1:0] light_on;
    logic [NumChan-1:0] light_off;
    logic [NumChan-1:0] warn_missing;
    logic [NumChan-1:0] sensor_back;
    logic [NumChan-1:0] present;
  } out_item_t;

  // Per-channel command for one transaction.
  typedef struct packed {
    logic              en;
    logic              pin_ev;
    logic              level;
    logic              check;
    logic              cancel;
    logic              restart;
    logic              manual;
    logic [TimeW-1:0]  now;
    logic [HoldW-1:0]  hold;
    logic [ShortW-1:0] glitch;
    logic [ShortW-1:0] valid_low;
  } chan_ctrl_t;

  // Per-channel result of one transaction.
  typedef struct packed {
    logic on;
    logic off;
    logic warn;
    logic back;
    logic present;
  } chan_stat_t;

endpackage

>>> src/pmlt_if.sv
interface pmlt_in_if;
  logic               valid;
  logic               ready;
  pmlt_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface pmlt_out_if;
  logic                valid;
  logic                ready;
  pmlt_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> src/pir_motion_light_timer.sv
// Channel   Dir  Handshake           Payload
// in_i      in   valid/ready         mode, pin_number, pin_level, channel, now_ms,
//                                    manual_outside, manual_entrance, suppress_events
// out_o     out  valid/ready         light_on, light_off, warn_missing, sensor_back, present
// cfg       in   cfg_we_i (no wait)  cfg_idx_i, cfg_wdata_i
//
// One transaction is accepted per clock cycle while the output is not stalled. An item
// waits in the input register, then the per-channel logic writes the result register
// and the channel state at the same edge.
// Reset clears the channel state, the valid flags and loads the register defaults.
// A stalled output holds its result; the input register keeps accepting while the
// output register is free or being drained in the same cycle.
module pir_motion_light_timer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  pmlt_in_if.sink                         in_i,
  pmlt_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [pmlt_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pmlt_pkg::CfgW-1:0]       cfg_wdata_i
);

  // Configuration registers.
  logic [pmlt_pkg::PinW-1:0]   pin_out_q, pin_ent_q;
  logic [pmlt_pkg::HoldW-1:0]  hold_out_q, hold_ent_q;
  logic [pmlt_pkg::ShortW-1:0] glitch_q, valid_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_out_q   <= pmlt_pkg::RST_PIN_OUTSIDE;
      pin_ent_q   <= pmlt_pkg::RST_PIN_ENTRANCE;
      hold_out_q  <= pmlt_pkg::RST_HOLD_TIME;
      hold_ent_q  <= pmlt_pkg::RST_HOLD_TIME;
      glitch_q    <= pmlt_pkg::RST_GLITCH_TIME;
      valid_low_q <= pmlt_pkg::RST_VALID_LOW_TIME;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pmlt_pkg::CFG_PIN_OUTSIDE:    pin_out_q   <= cfg_wdata_i[pmlt_pkg::PinW-1:0];
        pmlt_pkg::CFG_PIN_ENTRANCE:   pin_ent_q   <= cfg_wdata_i[pmlt_pkg::PinW-1:0];
        pmlt_pkg::CFG_HOLD_OUTSIDE:   hold_out_q  <= cfg_wdata_i[pmlt_pkg::HoldW-1:0];
        pmlt_pkg::CFG_HOLD_ENTRANCE:  hold_ent_q  <= cfg_wdata_i[pmlt_pkg::HoldW-1:0];
        pmlt_pkg::CFG_GLITCH_TIME:    glitch_q    <= cfg_wdata_i[pmlt_pkg::ShortW-1:0];
        pmlt_pkg::CFG_VALID_LOW_TIME: valid_low_q <= cfg_wdata_i[pmlt_pkg::ShortW-1:0];
        default: ;
      endcase
    end
  end

  // Input register and output register with a combinational ready chain.
  pmlt_pkg::in_item_t  in_q;
  logic                in_vld_q;
  pmlt_pkg::out_item_t out_q, result;
  logic                out_vld_q;
  logic                out_free, advance, in_fire;

  assign out_free   = !out_vld_q || out_o.ready;
  assign advance    = in_vld_q && out_free;
  assign in_i.ready = !in_vld_q || out_free;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_fire) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_i.payload;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  // Decode the item into one command per channel. When both channels share a pin,
  // the outside channel takes the event.
  logic                 pin_mode, hit_out, hit_ent, check;
  pmlt_pkg::chan_ctrl_t ctrl_out, ctrl_ent;
  pmlt_pkg::chan_stat_t stat_out, stat_ent;

  always_comb begin
    pin_mode = (in_q.mode == pmlt_pkg::MODE_PIN) && !in_q.suppress_events;
    hit_out  = pin_mode && (in_q.pin_number == pin_out_q);
    hit_ent  = pin_mode && !hit_out && (in_q.pin_number == pin_ent_q);
    // Expiry is checked on tick and pin items only, even when the event is dropped.
    check    = (in_q.mode == pmlt_pkg::MODE_TICK) || (in_q.mode == pmlt_pkg::MODE_PIN);

    ctrl_out.en        = advance;
    ctrl_out.pin_ev    = hit_out;
    ctrl_out.level     = in_q.pin_level;
    ctrl_out.check     = check;
    ctrl_out.cancel    = (in_q.mode == pmlt_pkg::MODE_CANCEL) && !in_q.channel;
    ctrl_out.restart   = (in_q.mode == pmlt_pkg::MODE_RESTART) && !in_q.channel;
    ctrl_out.manual    = in_q.manual_outside;
    ctrl_out.now       = in_q.now_ms;
    ctrl_out.hold      = hold_out_q;
    ctrl_out.glitch    = glitch_q;
    ctrl_out.valid_low = valid_low_q;

    ctrl_ent.en        = advance;
    ctrl_ent.pin_ev    = hit_ent;
    ctrl_ent.level     = in_q.pin_level;
    ctrl_ent.check     = check;
    ctrl_ent.cancel    = (in_q.mode == pmlt_pkg::MODE_CANCEL) && in_q.channel;
    ctrl_ent.restart   = (in_q.mode == pmlt_pkg::MODE_RESTART) && in_q.channel;
    ctrl_ent.manual    = in_q.manual_entrance;
    ctrl_ent.now       = in_q.now_ms;
    ctrl_ent.hold      = hold_ent_q;
    ctrl_ent.glitch    = glitch_q;
    ctrl_ent.valid_low = valid_low_q;
  end

  pmlt_chan u_chan_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl_out),
    .stat_o (stat_out)
  );

  pmlt_chan u_chan_ent (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl_ent),
    .stat_o (stat_ent)
  );

  // Bit 0 of each result field is the outside channel, bit 1 the entrance channel.
  always_comb begin
    result.light_on     = {stat_ent.on, stat_out.on};
    result.light_off    = {stat_ent.off, stat_out.off};
    result.warn_missing = {stat_ent.warn, stat_out.warn};
    result.sensor_back  = {stat_ent.back, stat_out.back};
    result.present      = {stat_ent.present, stat_out.present};
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

  // A warning and a recovery never fire together on one channel.
  a_warn_back_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((out_q.warn_missing & out_q.sensor_back) == '0))
    else $error("warning and recovery raised together");

  // A recovered sensor is reported present.
  a_back_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((out_q.sensor_back & ~out_q.present) == '0))
    else $error("recovered sensor not present");

  // A warned sensor is reported absent.
  a_warn_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((out_q.warn_missing & out_q.present) == '0))
    else $error("warned sensor reported present");

  // A transaction that leaves the input register shows up as a result next cycle.
  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("result lost after advance");

endmodule

>>> src/pmlt_chan.sv
module pmlt_chan (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pmlt_pkg::chan_ctrl_t ctrl_i,
  output pmlt_pkg::chan_stat_t stat_o
);

  logic                       last_q, last_d;
  logic                       valid_q, valid_d;
  logic                       warned_q, warned_d;
  logic [pmlt_pkg::TimeW-1:0] stamp_q, stamp_d;
  logic [pmlt_pkg::TimeW-1:0] dl_q, dl_d;

  logic [pmlt_pkg::TimeW-1:0] elapsed, sum, dl_mid, diff;
  logic stamp_seen, high_ev, past_glitch, low_ok, qualifies, missing, present_hit;
  logic on, expire;

  always_comb begin
    elapsed     = ctrl_i.now - stamp_q;
    sum         = ctrl_i.now + {{(pmlt_pkg::TimeW-pmlt_pkg::HoldW){1'b0}}, ctrl_i.hold};
    stamp_seen  = (stamp_q != '0);
    high_ev     = ctrl_i.pin_ev && ctrl_i.level;
    past_glitch = high_ev && stamp_seen &&
                  (elapsed >= {{(pmlt_pkg::TimeW-pmlt_pkg::ShortW){1'b0}}, ctrl_i.glitch});
    low_ok      = (elapsed >= {{(pmlt_pkg::TimeW-pmlt_pkg::ShortW){1'b0}}, ctrl_i.valid_low});
    qualifies   = past_glitch && (valid_q || low_ok);
    missing     = (high_ev && !stamp_seen) || (past_glitch && !valid_q && !low_ok);
    present_hit = (ctrl_i.pin_ev && !ctrl_i.level) || (past_glitch && !valid_q && low_ok);

    valid_d  = valid_q;
    warned_d = warned_q;
    stat_o   = '0;

    if (present_hit && !valid_q) begin
      valid_d = 1'b1;
      if (warned_q) begin
        warned_d    = 1'b0;
        stat_o.back = 1'b1;
      end
    end
    if (missing && !valid_q && !warned_q) begin
      warned_d    = 1'b1;
      stat_o.warn = 1'b1;
    end

    // A counted rising edge arms the deadline before expiry is checked.
    on     = qualifies && !last_q && !ctrl_i.manual;
    dl_mid = on ? sum : dl_q;
    diff   = ctrl_i.now - dl_mid;
    expire = ctrl_i.check && (dl_mid != '0) && !diff[pmlt_pkg::TimeW-1];

    if (ctrl_i.cancel) begin
      dl_d = '0;
    end else if (ctrl_i.restart) begin
      dl_d = sum;
    end else if (expire) begin
      dl_d = '0;
    end else begin
      dl_d = dl_mid;
    end

    last_d  = ctrl_i.pin_ev ? ctrl_i.level : last_q;
    stamp_d = (ctrl_i.pin_ev && !ctrl_i.level) ? ctrl_i.now : stamp_q;

    stat_o.on      = on;
    stat_o.off     = expire && !ctrl_i.manual;
    stat_o.present = valid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= 1'b0;
      valid_q  <= 1'b0;
      warned_q <= 1'b0;
      stamp_q  <= '0;
      dl_q     <= '0;
    end else if (ctrl_i.en) begin
      last_q   <= last_d;
      valid_q  <= valid_d;
      warned_q <= warned_d;
      stamp_q  <= stamp_d;
      dl_q     <= dl_d;
    end
  end

endmodule
